// ===== rtl/short_exposure_gain_compensation_core_assert.svh =====
// Assertion macros for the short-exposure gain compensation core.
// Needs nothing else; ASSERT_OFF turns every macro into an empty line.
`ifndef SHORT_EXPOSURE_GAIN_COMPENSATION_CORE_ASSERT_SVH
`define SHORT_EXPOSURE_GAIN_COMPENSATION_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sgc_pkg.sv =====
// Package of the short-exposure gain compensation core: types and constants.
// Used by every module of the core; depends on nothing.
package sgc_pkg;

	localparam int NUM_W = 32;
	localparam int DIV_W = 20;
	localparam int MHZ_SHIFT = 6;
	localparam int MHZ_DIV = 15625;
	localparam int MHZ_FRAC = 40;
	localparam logic [26:0] MHZ_RECIP = 27'd70368744;
	localparam logic [15:0] SHORT_LIMIT = 16'd15;

	typedef enum logic [2:0] {
		REG_PIXEL_CLOCK = 3'd0,
		REG_LINE_LENGTH = 3'd1,
		REG_MIN_FINE = 3'd2,
		REG_MIN_COARSE = 3'd3,
		REG_MIN_AGAIN = 3'd4,
		REG_MAX_AGAIN = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_UNCHANGED = 3'd0,
		ST_MIN_CLAMP = 3'd1,
		ST_DGAIN_SCALED = 3'd2,
		ST_AGAIN_COMP = 3'd3,
		ST_BAD_LINE = 3'd4,
		ST_ZERO_COARSE = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0] exposure_us;
		logic [31:0] analog_gain_in;
		logic [31:0] digital_gain_in;
	} item_t;

	typedef struct packed {
		logic [31:0] analog_gain_out;
		logic [31:0] digital_gain_out;
		logic [15:0] coarse_lines;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} lane_t;

	typedef struct packed {
		logic [31:0] again;
		logic [31:0] dgain;
		logic [31:0] fine;
	} tag1_t;

	typedef struct packed {
		logic [31:0] again;
		logic [31:0] dgain;
		logic [15:0] coarse;
		logic short_expo;
	} tag2_t;

endpackage

// ===== rtl/sgc_cell.sv =====
// One cell of a divider chain: one restoring quotient bit per lane per cycle.
// Depends on sgc_pkg.
module sgc_cell #(
	parameter int LANES = 1,
	parameter type tag_t = logic
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input sgc_pkg::lane_t [LANES-1:0] in_lanes,
	input logic [sgc_pkg::DIV_W-1:0] in_div,
	input tag_t in_tag,
	output logic out_valid,
	output sgc_pkg::lane_t [LANES-1:0] out_lanes,
	output logic [sgc_pkg::DIV_W-1:0] out_div,
	output tag_t out_tag
);
	import sgc_pkg::*;

	logic valid_q;
	lane_t [LANES-1:0] lanes_q;
	lane_t [LANES-1:0] lanes_d;
	logic [DIV_W-1:0] div_q;
	tag_t tag_q;

	always_comb begin
		logic [DIV_W:0] trial;
		logic ge;
		for (int i = 0; i < LANES; i++) begin
			trial = {in_lanes[i].rem, in_lanes[i].num[NUM_W-1]};
			ge = trial >= {1'b0, in_div};
			lanes_d[i].num = {in_lanes[i].num[NUM_W-2:0], 1'b0};
			lanes_d[i].quo = {in_lanes[i].quo[NUM_W-2:0], ge};
			lanes_d[i].rem = ge ? DIV_W'(trial - {1'b0, in_div}) : DIV_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= lanes_d;
		div_q <= in_div;
		tag_q <= in_tag;
	end

	assign out_valid = valid_q;
	assign out_lanes = lanes_q;
	assign out_div = div_q;
	assign out_tag = tag_q;
endmodule

// ===== rtl/sgc_chain.sv =====
// A row of divider cells that yields a full 32-bit quotient per lane.
// Depends on sgc_pkg and sgc_cell.
module sgc_chain #(
	parameter int LANES = 1,
	parameter type tag_t = logic
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input sgc_pkg::lane_t [LANES-1:0] in_lanes,
	input logic [sgc_pkg::DIV_W-1:0] in_div,
	input tag_t in_tag,
	output logic out_valid,
	output sgc_pkg::lane_t [LANES-1:0] out_lanes,
	output tag_t out_tag
);
	import sgc_pkg::*;

	logic v [NUM_W+1];
	lane_t [LANES-1:0] ln [NUM_W+1];
	logic [DIV_W-1:0] dv [NUM_W+1];
	tag_t tg [NUM_W+1];

	assign v[0] = in_valid;
	assign ln[0] = in_lanes;
	assign dv[0] = in_div;
	assign tg[0] = in_tag;

	for (genvar k = 0; k < NUM_W; k++) begin : g_cell
		sgc_cell #(.LANES(LANES), .tag_t(tag_t)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(v[k]),
			.in_lanes(ln[k]),
			.in_div(dv[k]),
			.in_tag(tg[k]),
			.out_valid(v[k+1]),
			.out_lanes(ln[k+1]),
			.out_div(dv[k+1]),
			.out_tag(tg[k+1])
		);
	end

	assign out_valid = v[NUM_W];
	assign out_lanes = ln[NUM_W];
	assign out_tag = tg[NUM_W];
endmodule

// ===== rtl/short_exposure_gain_compensation_core.sv =====
// Top level of the short-exposure gain compensation core.
// Depends on sgc_pkg, sgc_chain and the assertion macro header.
//
// A request is transferred on start while busy is low; item carries the
// exposure in microseconds and the requested analog and digital gains.
// Exactly one result follows, shown on result for one cycle with done high.
// In order, three stages work out the pixel clock in MHz and the
// fine time, a chain of 32 divider cells gives the coarse line count, one
// stage forms the gain products and the divisor, a second chain of 32
// two-lane cells divides both products, and a last stage selects the result.
// A new request may be transferred in every cycle; the divider chains set
// the latency, and requests overlap in them freely.
// The receiver cannot stall: each result is transferred in its one cycle.
// Registers are written over the cfg channel, whose ready is always high;
// they may change only while no request is in flight.
// Reset clears every pipeline valid and holds busy high for one cycle;
// the registers take their documented reset values.
`include "short_exposure_gain_compensation_core_assert.svh"
module short_exposure_gain_compensation_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input sgc_pkg::item_t item,
	output logic done,
	output sgc_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	import sgc_pkg::*;

	localparam int LAT = 2 * NUM_W + 5;

	logic [31:0] pixel_clock_q;
	logic [15:0] line_length_q;
	logic [15:0] min_fine_q;
	logic [15:0] min_coarse_q;
	logic [31:0] min_again_q;
	logic [31:0] max_again_q;
	logic busy_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	item_t item_s1, item_s2, item_s3;
	logic [52:0] prod_s1;
	logic [12:0] mhz_s2;
	logic [31:0] fine_s3;
	logic [25:0] clk_sh;
	logic [12:0] q0;
	logic [25:0] r0;

	lane_t [0:0] c1_in, c1_out;
	tag1_t t1_in, t1_out;
	logic c1_v;

	logic [15:0] c16, coarse_d;
	lane_t [1:0] lanes_s4, c2_out;
	logic [DIV_W-1:0] denom_s4;
	tag2_t tag_s4, t2_out;
	logic c2_v;
	result_t result_s5;

	assign cfg_ready = 1'b1;
	assign busy = busy_q;
	assign clk_sh = pixel_clock_q[31:MHZ_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_clock_q <= '0;
			line_length_q <= '0;
			min_fine_q <= '0;
			min_coarse_q <= 16'd1;
			min_again_q <= 32'd1000;
			max_again_q <= 32'd16000;
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PIXEL_CLOCK: pixel_clock_q <= cfg_data;
					REG_LINE_LENGTH: line_length_q <= cfg_data[15:0];
					REG_MIN_FINE: min_fine_q <= cfg_data[15:0];
					REG_MIN_COARSE: min_coarse_q <= cfg_data[15:0];
					REG_MIN_AGAIN: min_again_q <= cfg_data;
					REG_MAX_AGAIN: max_again_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= c1_v;
			v_s5 <= c2_v;
		end
	end

	always_comb begin
		q0 = prod_s1[MHZ_FRAC+12:MHZ_FRAC];
		r0 = clk_sh - 26'(q0 * 26'(MHZ_DIV));
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		prod_s1 <= 53'(clk_sh) * 53'(MHZ_RECIP);
		item_s2 <= item_s1;
		mhz_s2 <= (r0 >= 26'(MHZ_DIV)) ? q0 + 13'd1 : q0;
		item_s3 <= item_s2;
		fine_s3 <= 32'(item_s2.exposure_us * 32'(mhz_s2)) - 32'(min_fine_q);
	end

	always_comb begin
		c1_in[0].num = fine_s3;
		c1_in[0].quo = '0;
		c1_in[0].rem = '0;
		t1_in.again = item_s3.analog_gain_in;
		t1_in.dgain = item_s3.digital_gain_in;
		t1_in.fine = fine_s3;
	end

	sgc_chain #(.LANES(1), .tag_t(tag1_t)) u_coarse_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s3),
		.in_lanes(c1_in),
		.in_div(DIV_W'(line_length_q)),
		.in_tag(t1_in),
		.out_valid(c1_v),
		.out_lanes(c1_out),
		.out_tag(t1_out)
	);

	always_comb begin
		c16 = c1_out[0].quo[15:0];
		coarse_d = (c16 < min_coarse_q) ? min_coarse_q : c16;
	end

	always_ff @(posedge clk) begin
		lanes_s4[0].num <= 32'(t1_out.again * t1_out.fine);
		lanes_s4[1].num <= 32'(t1_out.dgain * t1_out.fine);
		lanes_s4[0].quo <= '0;
		lanes_s4[1].quo <= '0;
		lanes_s4[0].rem <= '0;
		lanes_s4[1].rem <= '0;
		denom_s4 <= DIV_W'(line_length_q) * DIV_W'(coarse_d[3:0]);
		tag_s4.again <= t1_out.again;
		tag_s4.dgain <= t1_out.dgain;
		tag_s4.coarse <= coarse_d;
		tag_s4.short_expo <= coarse_d <= SHORT_LIMIT;
	end

	sgc_chain #(.LANES(2), .tag_t(tag2_t)) u_gain_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.in_lanes(lanes_s4),
		.in_div(denom_s4),
		.in_tag(tag_s4),
		.out_valid(c2_v),
		.out_lanes(c2_out),
		.out_tag(t2_out)
	);

	always_ff @(posedge clk) begin
		result_s5.analog_gain_out <= t2_out.again;
		result_s5.digital_gain_out <= t2_out.dgain;
		result_s5.coarse_lines <= t2_out.coarse;
		result_s5.status <= ST_UNCHANGED;
		if (line_length_q == 16'd0) begin
			result_s5.coarse_lines <= '0;
			result_s5.status <= ST_BAD_LINE;
		end else if (t2_out.coarse == 16'd0) begin
			result_s5.status <= ST_ZERO_COARSE;
		end else if (t2_out.short_expo) begin
			if (c2_out[0].quo < min_again_q) begin
				result_s5.analog_gain_out <= min_again_q;
				result_s5.status <= ST_MIN_CLAMP;
			end else if (t2_out.again >= max_again_q) begin
				result_s5.digital_gain_out <= c2_out[1].quo;
				result_s5.status <= ST_DGAIN_SCALED;
			end else begin
				result_s5.analog_gain_out <= c2_out[0].quo;
				result_s5.status <= ST_AGAIN_COMP;
			end
		end
	end

	assign done = v_s5;
	assign result = result_s5;

	`SGC_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start && !busy, LAT))
	`SGC_ASSERT_IMP(a_bad_line, clk, arst_n, done && line_length_q == 16'd0, result.status == ST_BAD_LINE && result.coarse_lines == 16'd0)
	`SGC_ASSERT_IMP(a_min_clamp, clk, arst_n, done && result.status == ST_MIN_CLAMP, result.analog_gain_out == min_again_q)
	`SGC_ASSERT_NXT(a_busy_low, clk, arst_n, !busy, !busy)
endmodule

// ===== tb/sv/short_exposure_gain_compensation_core_tb.sv =====
// Self-checking testbench for short_exposure_gain_compensation_core.
// Depends on sgc_pkg and the core; it predicts every result and compares each one as it
// appears, over directed and random requests under several register settings.
module short_exposure_gain_compensation_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sgc_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] pclk_hz, line_len, min_fine, min_coarse, min_again, max_again;
	item_t pending_requests[$];
	result_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int gap = 0;
	bit took = 1'b0;
	bit no_gaps = 1'b0;

	short_exposure_gain_compensation_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic result_t compensate(item_t req);
		result_t r;
		logic [31:0] mhz, fine, coarse, denom, comp;
		r.analog_gain_out = req.analog_gain_in;
		r.digital_gain_out = req.digital_gain_in;
		r.coarse_lines = '0;
		if (line_len == 0) begin
			r.status = ST_BAD_LINE;
			return r;
		end
		mhz = pclk_hz / 32'd1000000;
		fine = req.exposure_us * mhz - min_fine;
		coarse = {16'd0, 16'(fine / line_len)};
		if (coarse < min_coarse) begin
			coarse = min_coarse;
		end
		if (coarse == 0) begin
			r.status = ST_ZERO_COARSE;
			return r;
		end
		r.coarse_lines = coarse[15:0];
		r.status = ST_UNCHANGED;
		if (coarse <= 32'(SHORT_LIMIT)) begin
			denom = line_len * coarse;
			comp = 32'(req.analog_gain_in * fine) / denom;
			if (comp < min_again) begin
				r.analog_gain_out = min_again;
				r.status = ST_MIN_CLAMP;
			end else if (req.analog_gain_in >= max_again) begin
				r.digital_gain_out = 32'(req.digital_gain_in * fine) / denom;
				r.status = ST_DGAIN_SCALED;
			end else begin
				r.analog_gain_out = comp;
				r.status = ST_AGAIN_COMP;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		took <= start && !busy;
		if (arst_n && start && !busy) begin
			expected_results.push_back(compensate(item));
		end
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.analog_gain_out !== want.analog_gain_out) begin
					$error("analog_gain_out: expected %0d, got %0d",
						want.analog_gain_out, result.analog_gain_out);
					errors++;
				end
				if (result.digital_gain_out !== want.digital_gain_out) begin
					$error("digital_gain_out: expected %0d, got %0d",
						want.digital_gain_out, result.digital_gain_out);
					errors++;
				end
				if (result.coarse_lines !== want.coarse_lines) begin
					$error("coarse_lines: expected %0d, got %0d",
						want.coarse_lines, result.coarse_lines);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					errors++;
				end
			end
		end
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("short_exposure_gain_compensation_core_tb: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		int r;
		if (!arst_n || (start && !took)) begin
		end else if (gap > 0) begin
			gap <= gap - 1;
			start <= 1'b0;
		end else if (pending_requests.size() != 0) begin
			start <= 1'b1;
			item <= pending_requests.pop_front();
			r = $urandom_range(0, 19);
			if (no_gaps || r < 13) begin
				gap <= 0;
			end else if (r < 18) begin
				gap <= $urandom_range(1, 3);
			end else begin
				gap <= $urandom_range(10, 40);
			end
		end else begin
			start <= 1'b0;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PIXEL_CLOCK: pclk_hz = data;
			REG_LINE_LENGTH: line_len = {16'd0, data[15:0]};
			REG_MIN_FINE: min_fine = {16'd0, data[15:0]};
			REG_MIN_COARSE: min_coarse = {16'd0, data[15:0]};
			REG_MIN_AGAIN: min_again = data;
			REG_MAX_AGAIN: max_again = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [31:0] pc, logic [31:0] ll, logic [31:0] mf,
			logic [31:0] mc, logic [31:0] mina, logic [31:0] maxa);
		write_reg(REG_PIXEL_CLOCK, pc);
		write_reg(REG_LINE_LENGTH, ll);
		write_reg(REG_MIN_FINE, mf);
		write_reg(REG_MIN_COARSE, mc);
		write_reg(REG_MIN_AGAIN, mina);
		write_reg(REG_MAX_AGAIN, maxa);
	endtask

	task automatic queue_request(logic [31:0] e, logic [31:0] a, logic [31:0] d);
		item_t it;
		it.exposure_us = e;
		it.analog_gain_in = a;
		it.digital_gain_in = d;
		pending_requests.push_back(it);
	endtask

	task automatic queue_random(int n);
		logic [31:0] mhz, e, a, d;
		for (int i = 0; i < n; i++) begin
			mhz = pclk_hz / 32'd1000000;
			if (mhz != 0 && line_len != 0 && $urandom_range(0, 9) < 7) begin
				e = ($urandom_range(0, 17 * line_len) + min_fine) / mhz;
			end else begin
				e = $urandom;
			end
			a = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40000) : $urandom;
			d = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40000) : $urandom;
			queue_request(e, a, d);
		end
	endtask

	task automatic drain;
		wait (pending_requests.size() == 0 && expected_results.size() == 0 && !start);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		pclk_hz = 0;
		line_len = 0;
		min_fine = 0;
		min_coarse = 1;
		min_again = 1000;
		max_again = 16000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_request(32'd1000, 32'd2000, 32'd3000);
		queue_request('1, '1, '1);
		drain();

		configure(100000000, 2000, 10, 1, 1000, 16000);
		write_reg(REG_UNUSED, 32'hDEADBEEF);
		queue_request(0, 0, 0);
		queue_request('1, '1, '1);
		queue_request(0, 32'd5000, 32'd1000);
		queue_request(1, 32'd4000, 32'd1000);
		queue_request(100, 32'd1000, 32'd1000);
		queue_request(100, 32'd1000, '1);
		queue_request(200, 32'd16000, 32'd2000);
		queue_request(200, '1, '1);
		queue_request(50, 32'd9000, 32'd1000);
		queue_request(300, 32'd15999, 32'd1000);
		queue_request(321, 32'd16000, 32'd1000);
		queue_request(5000, 32'd2000, 32'd3000);
		queue_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		drain();

		configure(100000000, 4000, 0, 0, 1000, 16000);
		queue_request(0, 32'd3000, 32'd4000);
		queue_request(39, 32'd3000, 32'd4000);
		queue_request(40, 32'd3000, 32'd4000);
		queue_random(60);
		drain();

		configure('1, 65535, 65535, 65535, '1, '1);
		queue_request(0, '1, '1);
		queue_random(60);
		drain();

		configure(24000000, 1, 0, 0, 0, 0);
		queue_request(0, 32'd1, 32'd1);
		queue_random(70);
		drain();

		configure(999999, 500, 3, 0, 500, 8000);
		queue_random(50);
		drain();

		no_gaps = 1'b1;
		configure(200000000, 3000, 200, 2, 2000, 4000);
		queue_random(90);
		drain();
		no_gaps = 1'b0;

		configure(48000000, 65535, 0, 1, 1000, 16000);
		queue_random(90);
		drain();

		configure(74250000, 2200, 1000, 4, 1000, 16000);
		queue_random(100);
		drain();

		configure(100000000, 1500, 50, 1, 0, 32'h8000_0000);
		queue_random(90);
		drain();

		configure(0, 800, 7, 3, 1000, 16000);
		queue_random(40);
		drain();

		configure(150000000, 1200, 30, 1, 1000, 16000);
		queue_random(100);
		drain();

		if (errors == 0) begin
			$display("short_exposure_gain_compensation_core_tb: clean");
		end else begin
			$display("short_exposure_gain_compensation_core_tb: errors");
		end
		$finish;
	end
endmodule
